### design/byte_stuffed_deframer_with_rings_core_macros.svh
// assertion macros for the deframer core
`ifndef BYTE_STUFFED_DEFRAMER_WITH_RINGS_CORE_MACROS_SVH
`define BYTE_STUFFED_DEFRAMER_WITH_RINGS_CORE_MACROS_SVH

// property that must hold after an enabling condition, checked on the next edge
`define BSD_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

// property that must hold in the same cycle
`define BSD_ASSERT_NOW(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

### design/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg
// constants, codes and the crc byte step for the byte-stuffed deframer
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    localparam logic CMD_LINE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_ACCEPT   = 3'd1;
    localparam logic [2:0] ST_UNROUTED = 3'd2;
    localparam logic [2:0] ST_SHORT    = 3'd3;
    localparam logic [2:0] ST_LENGTH   = 3'd4;
    localparam logic [2:0] ST_CRC      = 3'd5;
    localparam logic [2:0] ST_OVERFLOW = 3'd6;

    localparam logic [0:0] REG_CTRL = 1'd0;
    localparam logic [0:0] REG_REPL = 1'd1;

    // ring select
    localparam logic [1:0] RING_NONE = 2'd0;
    localparam logic [1:0] RING_CTRL = 2'd1;
    localparam logic [1:0] RING_REPL = 2'd2;

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_byte;
        logic [9:0] avail_count;
        logic [2:0] frame_status;
    } t_result;

    typedef struct packed {
        logic       command;
        logic [7:0] line_byte;
        logic [7:0] read_channel;
    } t_item;

    // one byte of crc16-ccitt, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

### design/bsd_stream_if.sv
// ----------------------------------------------------------------------------
// bsd_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface bsd_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/byte_stuffed_deframer_with_rings_core.sv
// ----------------------------------------------------------------------------
// byte_stuffed_deframer_with_rings_core
// hdlc-style byte-stuffed deframer with crc16 check and two receive rings
// ----------------------------------------------------------------------------
// A line beat and a read beat each pass through accept, work (frame memory
// write, or ring memory read of the tail entry), drain (ring pop), and the load
// of the result register. A closing delimiter of an accepted frame adds a
// payload copy from the frame memory into the ring memory, one byte a cycle
// through the single frame memory read port; the crc runs per byte as bytes
// arrive, so only the copy grows with frame length.
// One beat is worked on at a time. The result waits in its own output register,
// so the next beat is accepted and worked on while a result is stalled; its
// result then waits in the last stage and the input stalls.
`include "byte_stuffed_deframer_with_rings_core_macros.svh"
module byte_stuffed_deframer_with_rings_core #(
    parameter int MAX_PAYLOAD = 512,
    parameter int RING_DEPTH  = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsd_stream_if.sink   in_if,
    bsd_stream_if.source out_if,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    localparam int CAP = MAX_PAYLOAD + 5;
    localparam int FW  = $clog2(CAP + 1);
    localparam int FA  = $clog2(CAP);
    localparam int RA  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    typedef enum logic [2:0] {S_IDLE, S_WORK, S_COPY, S_DRAIN, S_OUT} t_state;
    t_state r_state;

    logic [7:0]  r_ctrl_ch, r_repl_ch;
    logic [7:0]  r_fmem [CAP];
    logic [7:0]  r_fdata;
    logic [FW-1:0] r_flen;
    logic        r_in_frame, r_esc;
    logic [15:0] r_crc, r_crc_prev, r_crc_prev2;
    logic [7:0]  r_ch;
    logic [15:0] r_len;
    logic [7:0]  r_b_1, r_b_2;
    bsd_pkg::t_item   r_item;
    bsd_pkg::t_result r_res;
    bsd_pkg::t_result r_out;
    logic [FW-1:0] r_cidx;
    logic [15:0]   r_cnt;
    logic [1:0]    r_cring;
    logic          r_cvalid;

    logic [7:0] w_byte;
    logic       push_c, push_r, pop_c, pop_r;
    logic [7:0] rd_c, rd_r;
    logic       emp_c, emp_r, full_c, full_r;
    logic [RA-1:0] cnt_c, cnt_r;
    logic [1:0] w_rsel, w_fsel;
    logic [FA-1:0] w_rdaddr;
    logic [2:0] w_status;
    logic [9:0] w_avail;

    bsd_ring #(.RING_DEPTH(RING_DEPTH)) u_ctrl (
        .i_clk, .i_rst_n, .i_push(push_c), .i_push_data(r_fdata), .i_pop(pop_c),
        .o_rd_data(rd_c), .o_empty(emp_c), .o_full(full_c), .o_count(cnt_c));
    bsd_ring #(.RING_DEPTH(RING_DEPTH)) u_repl (
        .i_clk, .i_rst_n, .i_push(push_r), .i_push_data(r_fdata), .i_pop(pop_r),
        .o_rd_data(rd_r), .o_empty(emp_r), .o_full(full_r), .o_count(cnt_r));

    // ring selection for read channel and for the frame's channel
    always_comb begin
        w_rsel = (r_item.read_channel == r_ctrl_ch) ? bsd_pkg::RING_CTRL :
                 (r_item.read_channel == r_repl_ch) ? bsd_pkg::RING_REPL : bsd_pkg::RING_NONE;
        w_fsel = (r_ch == r_ctrl_ch) ? bsd_pkg::RING_CTRL :
                 (r_ch == r_repl_ch) ? bsd_pkg::RING_REPL : bsd_pkg::RING_NONE;
        w_byte = r_esc ? (r_item.line_byte ^ bsd_pkg::ESC_XOR) : r_item.line_byte;
        w_rdaddr = r_cidx[FA-1:0];
    end

    // frame status of the beat in work: close checks in order, or overflow
    always_comb begin
        w_status = bsd_pkg::ST_NONE;
        if (r_item.command == bsd_pkg::CMD_LINE) begin
            if (r_item.line_byte == bsd_pkg::FLAG_BYTE) begin
                if (r_in_frame && r_flen != '0) begin
                    if (r_flen < FW'(5)) begin
                        w_status = bsd_pkg::ST_SHORT;
                    end else if ({16'd0, r_len} != 32'(r_flen) - 32'd5) begin
                        w_status = bsd_pkg::ST_LENGTH;
                    end else if (r_crc_prev2 != {r_b_2, r_b_1}) begin
                        w_status = bsd_pkg::ST_CRC;
                    end else if (w_fsel == bsd_pkg::RING_NONE) begin
                        w_status = bsd_pkg::ST_UNROUTED;
                    end else begin
                        w_status = bsd_pkg::ST_ACCEPT;
                    end
                end
            end else if (r_in_frame && r_item.line_byte != bsd_pkg::ESC_BYTE
                         && r_flen >= FW'(CAP)) begin
                w_status = bsd_pkg::ST_OVERFLOW;
            end
        end
    end

    // bytes waiting in the read channel's ring
    always_comb begin
        case (w_rsel)
            bsd_pkg::RING_CTRL: w_avail = 10'(cnt_c);
            bsd_pkg::RING_REPL: w_avail = 10'(cnt_r);
            default: w_avail = 10'd0;
        endcase
    end

    assign push_c = r_cvalid && (r_cring == bsd_pkg::RING_CTRL);
    assign push_r = r_cvalid && (r_cring == bsd_pkg::RING_REPL);
    assign pop_c  = (r_state == S_DRAIN) && r_item.command == bsd_pkg::CMD_READ
                    && w_rsel == bsd_pkg::RING_CTRL;
    assign pop_r  = (r_state == S_DRAIN) && r_item.command == bsd_pkg::CMD_READ
                    && w_rsel == bsd_pkg::RING_REPL;

    assign in_if.ready  = (r_state == S_IDLE);
    assign out_if.data  = r_out;

    // frame memory: write on data beats, read during the payload copy
    always_ff @(posedge i_clk) begin
        if (r_state == S_WORK && r_item.command == bsd_pkg::CMD_LINE && r_in_frame
            && r_item.line_byte != bsd_pkg::FLAG_BYTE && r_item.line_byte != bsd_pkg::ESC_BYTE
            && r_flen < FW'(CAP)) begin
            r_fmem[r_flen[FA-1:0]] <= w_byte;
        end
        r_fdata <= r_fmem[w_rdaddr];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_ch <= 8'd1;
            r_repl_ch <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bsd_pkg::REG_CTRL: r_ctrl_ch <= i_cfg_data;
                bsd_pkg::REG_REPL: r_repl_ch <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_flen     <= '0;
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
            r_crc      <= bsd_pkg::CRC_INIT;
            r_crc_prev <= bsd_pkg::CRC_INIT;
            r_crc_prev2 <= bsd_pkg::CRC_INIT;
            r_cvalid   <= 1'b0;
            r_cring    <= bsd_pkg::RING_NONE;
            out_if.valid <= 1'b0;
        end else begin
            // result register handshake
            if (r_state == S_OUT && (!out_if.valid || out_if.ready)) begin
                out_if.valid <= 1'b1;
            end else if (out_if.ready) begin
                out_if.valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_if.valid && in_if.ready) begin
                        r_item  <= in_if.data;
                        r_state <= S_WORK;
                    end
                end
                S_WORK: begin
                    r_res   <= bsd_pkg::t_result'{1'b0, 8'd0, 10'd0, w_status};
                    r_state <= (w_status == bsd_pkg::ST_ACCEPT) ? S_COPY : S_DRAIN;
                    if (w_status == bsd_pkg::ST_ACCEPT) begin
                        r_cring <= w_fsel;
                        r_cidx  <= FW'(3);
                        r_cnt   <= r_len;
                    end
                    if (r_item.command == bsd_pkg::CMD_LINE) begin
                        if (r_item.line_byte == bsd_pkg::FLAG_BYTE) begin
                            r_in_frame <= 1'b1;
                            r_flen <= '0;
                            r_esc  <= 1'b0;
                            r_crc <= bsd_pkg::CRC_INIT;
                            r_crc_prev <= bsd_pkg::CRC_INIT;
                            r_crc_prev2 <= bsd_pkg::CRC_INIT;
                        end else if (r_in_frame) begin
                            if (r_item.line_byte == bsd_pkg::ESC_BYTE) begin
                                r_esc <= 1'b1;
                            end else begin
                                r_esc <= 1'b0;
                                if (r_flen < FW'(CAP)) begin
                                    r_flen <= r_flen + FW'(1);
                                    r_crc_prev2 <= r_crc_prev;
                                    r_crc_prev  <= r_crc;
                                    r_crc <= bsd_pkg::crc_byte(r_crc, w_byte);
                                    r_b_2 <= w_byte;
                                    r_b_1 <= r_b_2;
                                    if (r_flen == FW'(0)) r_ch <= w_byte;
                                    if (r_flen == FW'(1)) r_len[7:0] <= w_byte;
                                    if (r_flen == FW'(2)) r_len[15:8] <= w_byte;
                                end else begin
                                    r_in_frame <= 1'b0;
                                end
                            end
                        end
                    end
                end
                S_COPY: begin
                    // read address leads the push through the registered frame memory read
                    if (r_cnt == 16'd0) begin
                        r_state  <= S_DRAIN;
                        r_cvalid <= 1'b0;
                    end else begin
                        r_cidx <= r_cidx + FW'(1);
                        r_cnt  <= r_cnt - 16'd1;
                        r_cvalid <= 1'b1;
                    end
                end
                S_DRAIN: begin
                    // pop happens here; ring read data already registered
                    if (r_item.command == bsd_pkg::CMD_READ) begin
                        case (w_rsel)
                            bsd_pkg::RING_CTRL: begin
                                r_res.read_valid <= !emp_c;
                                r_res.read_byte  <= emp_c ? 8'd0 : rd_c;
                            end
                            bsd_pkg::RING_REPL: begin
                                r_res.read_valid <= !emp_r;
                                r_res.read_byte  <= emp_r ? 8'd0 : rd_r;
                            end
                            default: ;
                        endcase
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // load the result once the output register is free
                    if (!out_if.valid || out_if.ready) begin
                        r_out <= bsd_pkg::t_result'{r_res.read_valid, r_res.read_byte,
                                                    w_avail, r_res.frame_status};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `BSD_ASSERT_NOW(a_ready_only_idle, i_clk, i_rst_n, in_if.ready, r_state == S_IDLE, "ready outside idle")
    `BSD_ASSERT_NOW(a_one_push, i_clk, i_rst_n, 1'b1, !(push_c && push_r), "both rings pushed")
    `BSD_ASSERT_NEXT(a_out_after, i_clk, i_rst_n, r_state == S_OUT, out_if.valid, "no result")
endmodule

### design/bsd_ring.sv
// ----------------------------------------------------------------------------
// bsd_ring
// receive ring: one synchronous memory with head and tail pointers
// ----------------------------------------------------------------------------
module bsd_ring #(
    parameter int RING_DEPTH = 1024,
    parameter int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_push_data,
    input  logic          i_pop,
    output logic [7:0]    o_rd_data,
    output logic          o_empty,
    output logic          o_full,
    output logic [AW-1:0] o_count
);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(RING_DEPTH);

    logic [7:0]    r_mem [RING_DEPTH];
    logic [AW-1:0] r_head, r_tail;
    logic [AW-1:0] n_head, n_tail;
    logic [AW:0]   w_diff;

    // pointer increments with wrap at any depth
    always_comb begin
        n_head = (r_head == AW'(RING_DEPTH - 1)) ? '0 : r_head + AW'(1);
        n_tail = (r_tail == AW'(RING_DEPTH - 1)) ? '0 : r_tail + AW'(1);
        w_diff = ({1'b0, r_head} >= {1'b0, r_tail}) ? {1'b0, r_head} - {1'b0, r_tail}
               : {1'b0, r_head} + DEPTH_W - {1'b0, r_tail};
    end

    assign o_empty = (r_head == r_tail);
    assign o_full  = (n_head == r_tail);
    assign o_count = w_diff[AW-1:0];

    // memory write and registered read of the tail entry
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_head] <= i_push_data;
        end
        o_rd_data <= r_mem[r_tail];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            if (i_push && !o_full) r_head <= n_head;
            if (i_pop && !o_empty) r_tail <= n_tail;
        end
    end
endmodule

### verif/tb_byte_stuffed_deframer_with_rings_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_stuffed_deframer_with_rings_core
// Drives line bytes and ring reads through the valid/ready channels. A
// behavioral copy of the deframer and its two rings predicts every result
// beat. The run covers directed corner frames, random well-formed and
// corrupted frames, and channel register changes between phases.
// ----------------------------------------------------------------------------

// behavioral deframer and rings, plus the queue of predicted result beats
class deframe_scoreboard;
    bit [7:0]    ctrl_ch = 8'd1;
    bit [7:0]    repl_ch = 8'd2;
    bit [7:0]    fbuf[517];
    int unsigned flen;
    bit          in_frame;
    bit          esc;
    bit [7:0]    ring_mem[2][1024];
    bit [9:0]    head[2];
    bit [9:0]    tail[2];
    bsd_pkg::t_result pending[$];
    int          errors;

    function bit [15:0] crc_update(input bit [15:0] crc, input bit [7:0] b);
        bit [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) c = (c << 1) ^ 16'h1021;
            else c = c << 1;
        end
        return c;
    endfunction

    // ring index of a channel, -1 when unrouted; control ring wins a tie
    function int ring_of(input bit [7:0] ch);
        if (ch == ctrl_ch) return 0;
        if (ch == repl_ch) return 1;
        return -1;
    endfunction

    function bit [2:0] close_frame();
        int unsigned len;
        bit [15:0] crc;
        bit [15:0] got;
        int r;
        if (flen < 5) return bsd_pkg::ST_SHORT;
        len = {fbuf[2], fbuf[1]};
        if (len != flen - 5) return bsd_pkg::ST_LENGTH;
        crc = 16'hFFFF;
        for (int i = 0; i < 3 + len; i++) crc = crc_update(crc, fbuf[i]);
        got = {fbuf[4 + len], fbuf[3 + len]};
        if (crc != got) return bsd_pkg::ST_CRC;
        r = ring_of(fbuf[0]);
        if (r < 0) return bsd_pkg::ST_UNROUTED;
        for (int i = 0; i < len; i++) begin
            if (10'(head[r] + 1) == tail[r]) break;
            ring_mem[r][head[r]] = fbuf[3 + i];
            head[r] = head[r] + 1;
        end
        return bsd_pkg::ST_ACCEPT;
    endfunction

    function void note(input bsd_pkg::t_item it);
        bsd_pkg::t_result res;
        bit [7:0] c;
        int r;
        res = '0;
        c = it.line_byte;
        if (it.command == bsd_pkg::CMD_LINE) begin
            if (c == bsd_pkg::FLAG_BYTE) begin
                if (in_frame && flen > 0) res.frame_status = close_frame();
                in_frame = 1;
                flen = 0;
                esc = 0;
            end else if (in_frame) begin
                if (c == bsd_pkg::ESC_BYTE) begin
                    esc = 1;
                end else begin
                    if (esc) begin
                        c = c ^ bsd_pkg::ESC_XOR;
                        esc = 0;
                    end
                    if (flen < 517) begin
                        fbuf[flen] = c;
                        flen++;
                    end else begin
                        in_frame = 0;
                        res.frame_status = bsd_pkg::ST_OVERFLOW;
                    end
                end
            end
        end
        r = ring_of(it.read_channel);
        if (r >= 0) begin
            if (it.command == bsd_pkg::CMD_READ && head[r] != tail[r]) begin
                res.read_valid = 1;
                res.read_byte = ring_mem[r][tail[r]];
                tail[r] = tail[r] + 1;
            end
            res.avail_count = head[r] - tail[r];
        end
        pending.push_back(res);
    endfunction

    function void check(input bsd_pkg::t_result got);
        bsd_pkg::t_result want;
        if (pending.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.read_valid !== want.read_valid) begin
            $error("read_valid expected %0d got %0d", want.read_valid, got.read_valid);
            errors++;
        end
        if (got.read_byte !== want.read_byte) begin
            $error("read_byte expected %0h got %0h", want.read_byte, got.read_byte);
            errors++;
        end
        if (got.avail_count !== want.avail_count) begin
            $error("avail_count expected %0d got %0d", want.avail_count, got.avail_count);
            errors++;
        end
        if (got.frame_status !== want.frame_status) begin
            $error("frame_status expected %0d got %0d", want.frame_status, got.frame_status);
            errors++;
        end
    endfunction
endclass

module tb_byte_stuffed_deframer_with_rings_core;

    localparam int WATCHDOG_LIMIT = 20000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    bsd_stream_if #(.T(bsd_pkg::t_item))   in_if ();
    bsd_stream_if #(.T(bsd_pkg::t_result)) out_if ();

    byte_stuffed_deframer_with_rings_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_if      (in_if),
        .out_if     (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    deframe_scoreboard sb = new;
    int  sent_items;
    bit  send_busy;
    bit  recv_busy;
    bit  hold_req;
    int  idle_cycles = 0;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // sender: one beat, optional gap before it
    task automatic send_item(input bsd_pkg::t_item it);
        int g;
        g = send_busy ? 0 : $urandom_range(0, 19);
        if (g > 0) begin
            in_if.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note(it);
        sent_items++;
        @(negedge i_clk);
    endtask

    function automatic bit [7:0] pick_channel();
        case ($urandom_range(0, 3))
            0: return sb.ctrl_ch;
            1: return sb.repl_ch;
            2: return 8'($urandom);
            default: return $urandom_range(0, 1) ? sb.ctrl_ch : sb.repl_ch;
        endcase
    endfunction

    task automatic send_line(input bit [7:0] b);
        bsd_pkg::t_item it;
        it.command      = bsd_pkg::CMD_LINE;
        it.line_byte    = b;
        it.read_channel = pick_channel();
        send_item(it);
    endtask

    task automatic send_read(input bit [7:0] ch);
        bsd_pkg::t_item it;
        it.command      = bsd_pkg::CMD_READ;
        it.line_byte    = 8'($urandom);
        it.read_channel = ch;
        send_item(it);
    endtask

    // stuffed data byte; sometimes escapes an ordinary byte too
    task automatic send_stuffed(input bit [7:0] b);
        bit [7:0] x;
        x = b ^ bsd_pkg::ESC_XOR;
        if (b == bsd_pkg::FLAG_BYTE || b == bsd_pkg::ESC_BYTE ||
            (x != bsd_pkg::FLAG_BYTE && x != bsd_pkg::ESC_BYTE
             && $urandom_range(0, 15) == 0)) begin
            send_line(bsd_pkg::ESC_BYTE);
            send_line(x);
        end else begin
            send_line(b);
        end
    endtask

    // kind: 0 good, 1 wrong length field, 2 bad crc, 3 too short
    task automatic send_frame(input bit [7:0] ch, input int n, input int kind);
        bit [7:0]  raw[$];
        bit [15:0] lenf;
        bit [15:0] crc;
        int        keep;
        lenf = 16'(n) + ((kind == 1) ? 16'($urandom_range(1, 3)) : 16'd0);
        raw = {ch, lenf[7:0], lenf[15:8]};
        repeat (n) raw.push_back(8'($urandom));
        crc = 16'hFFFF;
        foreach (raw[i]) crc = sb.crc_update(crc, raw[i]);
        if (kind == 2) crc = crc ^ (16'd1 << $urandom_range(0, 15));
        raw.push_back(crc[7:0]);
        raw.push_back(crc[15:8]);
        if (kind == 3) begin
            keep = $urandom_range(1, 4);
            while (raw.size() > keep) void'(raw.pop_back());
        end
        send_line(bsd_pkg::FLAG_BYTE);
        foreach (raw[i]) send_stuffed(raw[i]);
        send_line(bsd_pkg::FLAG_BYTE);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, 12);
        if (r < 98) return $urandom_range(13, 40);
        return $urandom_range(41, 80);
    endfunction

    // random mix of frames, noise and read bursts
    task automatic random_phase(input int n_items);
        int stop_at;
        int r;
        stop_at = sent_items + n_items;
        while (sent_items < stop_at) begin
            send_busy = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 50) begin
                send_frame(pick_channel(), pick_len(), 0);
            end else if (r < 62) begin
                send_frame(pick_channel(), pick_len(), $urandom_range(1, 3));
            end else if (r < 68) begin
                repeat ($urandom_range(1, 6)) send_line(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 10)) send_read(pick_channel());
            end
        end
        send_busy = 1'b0;
    endtask

    // register write while nothing is in flight
    task automatic write_reg(input logic [0:0] idx, input bit [7:0] val);
        in_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bsd_pkg::REG_CTRL) sb.ctrl_ch = val;
        else sb.repl_ch = val;
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        int g;
        int burst_left;
        out_if.ready = 1'b0;
        burst_left = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (burst_left == 0) begin
                recv_busy = ($urandom_range(0, 2) == 0);
                burst_left = $urandom_range(10, 60);
            end
            burst_left--;
            g = recv_busy ? 0 : $urandom_range(0, 19);
            if (hold_req) begin
                hold_req = 1'b0;
                g = 400;
            end
            if (g > 0) begin
                out_if.ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            sb.check(out_if.data);
            @(negedge i_clk);
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("tb_byte_stuffed_deframer_with_rings_core failed");
            $finish;
        end
    end

    // main sequence
    initial begin
        in_if.valid = 1'b0;
        in_if.data  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        sent_items  = 0;
        send_busy   = 1'b0;
        hold_req    = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: bytes outside a frame, empty frame, short, bad length, bad crc
        send_line(8'h00);
        send_line(8'hFF);
        send_line(bsd_pkg::FLAG_BYTE);
        send_line(bsd_pkg::FLAG_BYTE);
        send_frame(8'd1, 0, 3);
        send_frame(8'd1, 2, 1);
        send_frame(8'd2, 1, 2);
        // repeated escape then an escaped byte, and an escape cleared by a flag
        send_line(bsd_pkg::FLAG_BYTE);
        send_line(bsd_pkg::ESC_BYTE);
        send_line(bsd_pkg::ESC_BYTE);
        send_line(8'h5D);
        send_line(bsd_pkg::ESC_BYTE);
        // good frames to both rings, an unrouted one, reads incl. empty and unrouted
        send_frame(8'd1, 3, 0);
        send_frame(8'd2, 0, 0);
        send_frame(8'd3, 2, 0);
        send_read(8'd1);
        send_read(8'd2);
        send_read(8'd3);
        send_read(8'd2);

        // long receiver hold-off while the sender keeps offering beats
        hold_req = 1'b1;
        random_phase(50);

        // overflow: more data than the frame buffer holds
        send_line(bsd_pkg::FLAG_BYTE);
        repeat (520) send_line(8'($urandom_range(0, 8'h7C)));
        send_line(bsd_pkg::FLAG_BYTE);

        // extremes of the channel registers
        write_reg(bsd_pkg::REG_CTRL, 8'd0);
        write_reg(bsd_pkg::REG_REPL, 8'd255);
        send_frame(8'd0, 4, 0);
        send_frame(8'd255, 4, 0);
        random_phase(40);

        // same channel on both registers
        write_reg(bsd_pkg::REG_CTRL, 8'd7);
        write_reg(bsd_pkg::REG_REPL, 8'd7);
        random_phase(40);

        // ring full: two largest frames into the control ring, no reads between
        write_reg(bsd_pkg::REG_CTRL, 8'($urandom));
        write_reg(bsd_pkg::REG_REPL, 8'($urandom));
        send_frame(sb.ctrl_ch, 512, 0);
        send_frame(sb.ctrl_ch, 512, 0);
        repeat (20) send_read(sb.ctrl_ch);
        random_phase(40);

        in_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_byte_stuffed_deframer_with_rings_core passed");
        end else begin
            $display("tb_byte_stuffed_deframer_with_rings_core failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/bsd_pkg.sv
design/bsd_stream_if.sv
design/bsd_ring.sv
design/byte_stuffed_deframer_with_rings_core.sv
verif/tb_byte_stuffed_deframer_with_rings_core.sv
